@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// Each macro expands to one labelled concurrent assertion, clocked and reset-qualified.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted, with a fixed message.
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Clocked assertion, disabled while reset is asserted, with a caller message.
`define ASSERT_CLK_MSG(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

@@ rtl/ifsf_pkg.sv @@
// Shared types, constants and helper functions of the stuffing framer.
// Used by every module of the block; depends on nothing.
package ifsf_pkg;

    localparam int unsigned DATA_W          = 8;
    localparam int unsigned CORRUPT_W       = 16;
    localparam int unsigned PADDR_W         = 5;
    localparam int unsigned PDATA_W         = 32;
    localparam int unsigned SEQ_SHIFT       = 6;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [DATA_W-1:0]    FLAG_RST    = 8'h7E;
    localparam logic [DATA_W-1:0]    ESCAPE_RST  = 8'h7D;
    localparam logic [DATA_W-1:0]    MASK_RST    = 8'h20;
    localparam logic [DATA_W-1:0]    ADDRESS_RST = 8'h03;
    localparam logic [CORRUPT_W-1:0] CORRUPT_RST = 16'h0000;

    typedef enum logic [2:0] {
        REG_FLAG    = 3'd0,
        REG_ESCAPE  = 3'd1,
        REG_MASK    = 3'd2,
        REG_ADDRESS = 3'd3,
        REG_CORRUPT = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] flag_byte;
        logic [DATA_W-1:0] escape_byte;
        logic [DATA_W-1:0] stuff_mask;
        logic [DATA_W-1:0] address_byte;
    } cfg_t;

    // One classified payload byte, as handed from the front end to the emitter.
    typedef struct packed {
        logic              hdr;
        logic              seq;
        logic [DATA_W-1:0] data;
        logic              last;
        logic [DATA_W-1:0] check;
    } cmd_t;

    typedef struct packed {
        logic [CORRUPT_W-1:0] value;
        logic                 load;
    } corrupt_wr_t;

    function automatic logic needs_stuff(input logic [DATA_W-1:0] b, input cfg_t cfg);
        return (b == cfg.flag_byte) || (b == cfg.escape_byte);
    endfunction

endpackage

@@ rtl/ifsf_regs.sv @@
// Configuration register file behind the APB-style port.
// Depends on ifsf_pkg for the register map and the configuration struct.
module ifsf_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ifsf_pkg::PADDR_W-1:0]   paddr,
    input  logic [ifsf_pkg::PDATA_W-1:0]   pwdata,
    output logic [ifsf_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output ifsf_pkg::cfg_t                 cfg,
    output ifsf_pkg::corrupt_wr_t          corrupt_wr
);
    import ifsf_pkg::*;

    logic [DATA_W-1:0]    flag_reg;
    logic [DATA_W-1:0]    escape_reg;
    logic [DATA_W-1:0]    mask_reg;
    logic [DATA_W-1:0]    address_reg;
    logic [CORRUPT_W-1:0] corrupt_reg;
    logic                 wr_en;
    reg_idx_t             idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg    <= FLAG_RST;
            escape_reg  <= ESCAPE_RST;
            mask_reg    <= MASK_RST;
            address_reg <= ADDRESS_RST;
            corrupt_reg <= CORRUPT_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_FLAG:    flag_reg    <= pwdata[DATA_W-1:0];
                REG_ESCAPE:  escape_reg  <= pwdata[DATA_W-1:0];
                REG_MASK:    mask_reg    <= pwdata[DATA_W-1:0];
                REG_ADDRESS: address_reg <= pwdata[DATA_W-1:0];
                REG_CORRUPT: corrupt_reg <= pwdata[CORRUPT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_FLAG:    prdata = PDATA_W'(flag_reg);
            REG_ESCAPE:  prdata = PDATA_W'(escape_reg);
            REG_MASK:    prdata = PDATA_W'(mask_reg);
            REG_ADDRESS: prdata = PDATA_W'(address_reg);
            REG_CORRUPT: prdata = PDATA_W'(corrupt_reg);
            default:     prdata = '0;
        endcase
    end

    assign cfg.flag_byte    = flag_reg;
    assign cfg.escape_byte  = escape_reg;
    assign cfg.stuff_mask   = mask_reg;
    assign cfg.address_byte = address_reg;

    // Every write of the fault-injection register reloads the frame countdown.
    assign corrupt_wr.load  = wr_en && (idx == REG_CORRUPT);
    assign corrupt_wr.value = pwdata[CORRUPT_W-1:0];

endmodule

@@ rtl/ifsf_front.sv @@
// Front end: accepts payload bytes, tracks the open frame, the payload check
// and the fault-injection countdown, and pushes classified commands. Uses ifsf_pkg.
module ifsf_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ifsf_pkg::DATA_W-1:0]   s_tdata,
    input  logic                          s_tlast,
    input  logic [1:0]                    s_tuser,
    input  ifsf_pkg::corrupt_wr_t         corrupt_wr,
    input  logic                          queue_full,
    output logic                          push,
    output ifsf_pkg::cmd_t                cmd
);
    import ifsf_pkg::*;

    logic                 open_reg;
    logic [DATA_W-1:0]    check_reg;
    logic [CORRUPT_W-1:0] corrupt_left_reg;
    logic                 accept;
    logic                 first;
    logic [DATA_W-1:0]    sum;
    logic                 corrupt;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign first    = s_tuser[0];

    // A byte that neither opens a frame nor falls inside one is dropped here.
    assign push     = accept && (first || open_reg);

    assign sum      = (first ? '0 : check_reg) ^ s_tdata;
    assign corrupt  = (corrupt_left_reg != '0);

    assign cmd.hdr   = first;
    assign cmd.seq   = s_tuser[1];
    assign cmd.data  = s_tdata;
    assign cmd.last  = s_tlast;
    assign cmd.check = corrupt ? '0 : sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg         <= 1'b0;
            check_reg        <= '0;
            corrupt_left_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                open_reg  <= !s_tlast;
                check_reg <= s_tlast ? '0 : sum;
            end
            if (corrupt_wr.load)
            begin
                corrupt_left_reg <= corrupt_wr.value;
            end
            else if (push && s_tlast && corrupt)
            begin
                corrupt_left_reg <= corrupt_left_reg - CORRUPT_W'(1);
            end
        end
    end

endmodule

@@ rtl/ifsf_queue.sv @@
// Short command queue between the front end and the emitter.
// Register-based, power-of-two depth; uses ifsf_pkg for the command type.
module ifsf_queue
#(
    parameter int unsigned DEPTH = ifsf_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ifsf_pkg::cmd_t push_cmd,
    input  logic           pop,
    output ifsf_pkg::cmd_t head,
    output logic           full,
    output logic           empty
);
    import ifsf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rptr_reg];

    always_comb
    begin
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wptr_reg <= wptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/ifsf_back.sv @@
// Emitter: walks the byte slots of the command at the queue head and drives
// the registered output stream one byte per cycle while m_tready allows. Uses ifsf_pkg.
module ifsf_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ifsf_pkg::cfg_t                cfg,
    input  ifsf_pkg::cmd_t                head,
    input  logic                          empty,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ifsf_pkg::DATA_W-1:0]   m_tdata,
    output logic                          m_tlast
);
    import ifsf_pkg::*;

    typedef enum logic [9:0] {
        S_START = 10'b0000000001,
        S_FLAG  = 10'b0000000010,
        S_ADDR  = 10'b0000000100,
        S_CTRL  = 10'b0000001000,
        S_HCHK  = 10'b0000010000,
        S_DESC  = 10'b0000100000,
        S_DATA  = 10'b0001000000,
        S_CESC  = 10'b0010000000,
        S_CHK   = 10'b0100000000,
        S_CLOSE = 10'b1000000000
    } slot_t;

    slot_t             slot_reg;
    slot_t             slot_next;
    slot_t             eff;
    slot_t             nxt;
    logic              valid_reg;
    logic [DATA_W-1:0] data_reg;
    logic              last_reg;
    logic [DATA_W-1:0] ctrl;
    logic              data_st;
    logic              chk_st;
    logic [DATA_W-1:0] byte_val;
    logic              byte_end;
    logic              done;
    logic              out_load;

    assign ctrl    = DATA_W'(head.seq) << SEQ_SHIFT;
    assign data_st = needs_stuff(head.data, cfg);
    assign chk_st  = needs_stuff(head.check, cfg);

    // At the start of a command the first slot is picked from the command itself.
    always_comb
    begin
        if (slot_reg == S_START)
        begin
            if (head.hdr)
            begin
                eff = S_FLAG;
            end
            else if (data_st)
            begin
                eff = S_DESC;
            end
            else
            begin
                eff = S_DATA;
            end
        end
        else
        begin
            eff = slot_reg;
        end
    end

    always_comb
    begin
        byte_end = 1'b0;
        done     = 1'b0;
        nxt      = S_START;
        case (eff)
            S_FLAG:
            begin
                byte_val = cfg.flag_byte;
                nxt      = S_ADDR;
            end
            S_ADDR:
            begin
                byte_val = cfg.address_byte;
                nxt      = S_CTRL;
            end
            S_CTRL:
            begin
                byte_val = ctrl;
                nxt      = S_HCHK;
            end
            S_HCHK:
            begin
                byte_val = cfg.address_byte ^ ctrl;
                nxt      = data_st ? S_DESC : S_DATA;
            end
            S_DESC:
            begin
                byte_val = cfg.escape_byte;
                nxt      = S_DATA;
            end
            S_DATA:
            begin
                byte_val = data_st ? (head.data ^ cfg.stuff_mask) : head.data;
                if (!head.last)
                begin
                    done = 1'b1;
                end
                else
                begin
                    nxt = chk_st ? S_CESC : S_CHK;
                end
            end
            S_CESC:
            begin
                byte_val = cfg.escape_byte;
                nxt      = S_CHK;
            end
            S_CHK:
            begin
                byte_val = chk_st ? (head.check ^ cfg.stuff_mask) : head.check;
                nxt      = S_CLOSE;
            end
            S_CLOSE:
            begin
                byte_val = cfg.flag_byte;
                byte_end = 1'b1;
                done     = 1'b1;
            end
            default:
            begin
                byte_val = cfg.flag_byte;
                done     = 1'b1;
            end
        endcase
    end

    // The output register takes a new byte when the queue holds a command and the register is empty or being drained.
    assign out_load  = !empty && (!valid_reg || m_tready);
    assign pop       = out_load && done;
    assign slot_next = out_load ? (done ? S_START : nxt) : slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= S_START;
            valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg <= slot_next;
            if (out_load)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            data_reg <= byte_val;
            last_reg <= byte_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

@@ rtl/info_frame_stuffing_framer.sv @@
// Stuffing framer with XOR block checks: top level.
// Payload bytes enter on the s_ stream, framed bytes leave on the m_ stream.
// Each accepted payload byte yields one to nine output bytes: with a first mark
// the header (flag, address, control, header check) comes before it, a flag or
// escape value is sent as escape then the byte XOR the mask, and with a last
// mark the stuffed payload check and the closing flag (tlast high) follow.
// A byte with no first mark outside an open frame yields nothing.
// The front end classifies each transaction combinationally and writes it to a
// QUEUE_DEPTH-entry command queue; the emitter sends one byte per cycle, while
// the receiver takes them, from the queue head through an output register. The
// first output byte of an item passes through the queue and then the output
// register; the queue takes new transactions while the emitter still sends
// earlier ones, so plain mid-frame bytes stream at one per cycle when the
// receiver does not stall, and a stuffed byte yields two output bytes.
// When the receiver holds m_tready low the output byte is held, the queue fills
// and s_tready falls; nothing is lost. Reset empties the queue, closes any frame
// and restores the register defaults. The user must write registers through the
// APB port only while the block is idle (not enforced); pready is always high.
module info_frame_stuffing_framer
#(
    parameter int unsigned QUEUE_DEPTH = ifsf_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ifsf_pkg::DATA_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,
    input  logic [1:0]                     s_tuser,   // [0] first_byte, [1] seq_bit
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ifsf_pkg::DATA_W-1:0]    m_tdata,   // [7:0] out_byte
    output logic                           m_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ifsf_pkg::PADDR_W-1:0]   paddr,
    input  logic [ifsf_pkg::PDATA_W-1:0]   pwdata,
    output logic [ifsf_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import ifsf_pkg::*;

    cfg_t        cfg;
    corrupt_wr_t corrupt_wr;
    cmd_t        push_cmd;
    cmd_t        head;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;

    ifsf_regs u_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cfg        (cfg),
        .corrupt_wr (corrupt_wr)
    );

    ifsf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .corrupt_wr (corrupt_wr),
        .queue_full (full),
        .push       (push),
        .cmd        (push_cmd)
    );

    ifsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    ifsf_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/ifsf_checker.sv @@
// Port-level checker for the stuffing framer, bound to the top level.
// Depends on ifsf_pkg for widths and on assert_macros.svh for the assertion form.
`include "assert_macros.svh"

module ifsf_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ifsf_pkg::DATA_W-1:0]    m_tdata,
    input  logic                           m_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ifsf_pkg::PADDR_W-1:0]   paddr,
    input  logic [ifsf_pkg::PDATA_W-1:0]   pwdata,
    input  logic [ifsf_pkg::PDATA_W-1:0]   prdata,
    input  logic                           pready
);
    import ifsf_pkg::*;

    // A stalled output byte must not change or vanish.
    `ASSERT_CLK_MSG(a_out_hold, clk, rst_n,
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)),
        "output changed while stalled")

    // Every closing flag is preceded by a check byte, so two cannot follow one another.
    `ASSERT_CLK_MSG(a_no_double_close, clk, rst_n,
        (m_tvalid && m_tready && m_tlast) |=> !(m_tvalid && m_tlast),
        "closing flags back to back")

    // A flag write is read back in the next cycle.
    `ASSERT_CLK_MSG(a_flag_readback, clk, rst_n,
        (psel && penable && pwrite && (paddr == '0)) ##1 (paddr == '0)
            |-> (prdata[DATA_W-1:0] == $past(pwdata[DATA_W-1:0])),
        "flag register readback mismatch")

    `ASSERT_CLK(a_pready_high, clk, rst_n, pready)

endmodule

bind info_frame_stuffing_framer ifsf_checker u_ifsf_checker (.*);

@@ tb/tb_info_frame_stuffing_framer.sv @@
// Self-checking testbench of the stuffing framer, with a scoreboard class that predicts
// every framed byte from the accepted payload transactions and the register settings.
// Depends on ifsf_pkg and on info_frame_stuffing_framer.
module tb_info_frame_stuffing_framer;
    import ifsf_pkg::*;

    localparam int REG_COUNT = 5;

    typedef struct {
        logic [DATA_W-1:0] out_byte;
        logic              frame_end;
    } framed_byte_t;

    class frame_scoreboard;
        logic [DATA_W-1:0]    flag_byte;
        logic [DATA_W-1:0]    escape_byte;
        logic [DATA_W-1:0]    stuff_mask;
        logic [DATA_W-1:0]    address_byte;
        logic [CORRUPT_W-1:0] corrupt_frames;
        logic [CORRUPT_W-1:0] corrupt_left;
        logic [DATA_W-1:0]    running_check;
        bit                   frame_open;
        framed_byte_t         expected_bytes[$];
        int                   errors;

        function new();
            flag_byte      = FLAG_RST;
            escape_byte    = ESCAPE_RST;
            stuff_mask     = MASK_RST;
            address_byte   = ADDRESS_RST;
            corrupt_frames = CORRUPT_RST;
            corrupt_left   = '0;
            running_check  = '0;
            frame_open     = 1'b0;
            errors         = 0;
        endfunction

        function void report(string what, logic [31:0] got, logic [31:0] want);
            if (errors < 100)
                $display("[%0t] MISMATCH %s: got %0h, wanted %0h", $realtime, what, got, want);
            errors++;
        endfunction

        function void write_reg(int idx, logic [31:0] value);
            case (idx)
                REG_FLAG:    flag_byte    = value[DATA_W-1:0];
                REG_ESCAPE:  escape_byte  = value[DATA_W-1:0];
                REG_MASK:    stuff_mask   = value[DATA_W-1:0];
                REG_ADDRESS: address_byte = value[DATA_W-1:0];
                REG_CORRUPT:
                begin
                    corrupt_frames = value[CORRUPT_W-1:0];
                    corrupt_left   = value[CORRUPT_W-1:0];
                end
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(int idx);
            case (idx)
                REG_FLAG:    return 32'(flag_byte);
                REG_ESCAPE:  return 32'(escape_byte);
                REG_MASK:    return 32'(stuff_mask);
                REG_ADDRESS: return 32'(address_byte);
                REG_CORRUPT: return 32'(corrupt_frames);
                default:     return '0;
            endcase
        endfunction

        function void push_byte(logic [DATA_W-1:0] b, logic frame_end);
            framed_byte_t item;
            item.out_byte  = b;
            item.frame_end = frame_end;
            expected_bytes.push_back(item);
        endfunction

        function void push_stuffed(logic [DATA_W-1:0] b);
            if (b == flag_byte || b == escape_byte)
            begin
                push_byte(escape_byte, 1'b0);
                push_byte(b ^ stuff_mask, 1'b0);
            end
            else
                push_byte(b, 1'b0);
        endfunction

        // Returns 1 when the transaction belongs to a frame, 0 when it is dropped.
        function bit note_payload(logic [DATA_W-1:0] data, logic first, logic last,
                                  logic seq);
            logic [DATA_W-1:0] ctrl;
            logic [DATA_W-1:0] check;
            if (first)
            begin
                ctrl = DATA_W'(seq) << SEQ_SHIFT;
                push_byte(flag_byte, 1'b0);
                push_byte(address_byte, 1'b0);
                push_byte(ctrl, 1'b0);
                push_byte(address_byte ^ ctrl, 1'b0);
                running_check = '0;
                frame_open    = 1'b1;
            end
            else if (!frame_open)
                return 1'b0;
            push_stuffed(data);
            running_check ^= data;
            if (last)
            begin
                check = running_check;
                if (corrupt_left != 0)
                begin
                    check = '0;
                    corrupt_left--;
                end
                push_stuffed(check);
                push_byte(flag_byte, 1'b1);
                running_check = '0;
                frame_open    = 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_output(logic [DATA_W-1:0] out_byte, logic frame_end);
            framed_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                report("unexpected output byte", 32'(out_byte), '0);
                return;
            end
            want = expected_bytes.pop_front();
            if (out_byte !== want.out_byte)
                report("out_byte", 32'(out_byte), 32'(want.out_byte));
            if (frame_end !== want.frame_end)
                report("frame_end", 32'(frame_end), 32'(want.frame_end));
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata  = '0;   // [7:0] data_byte
    logic                s_tlast  = 1'b0;
    logic [1:0]          s_tuser  = '0;   // [0] first_byte, [1] seq_bit
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;         // [7:0] out_byte
    logic                m_tlast;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [PDATA_W-1:0]  pwdata   = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    frame_scoreboard sb;
    bit              idle_on    = 1'b1;
    int              stall_left = 0;

    info_frame_stuffing_framer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Receiver: checks each output transaction and, while idle_on is set, stalls in short random bursts.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_output(m_tdata, m_tlast);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            stall_left <= $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Called at a rising edge; returns at the edge where the transaction was accepted.
    task automatic send_payload(input logic [DATA_W-1:0] data, input logic first,
                                input logic last, input logic seq, output bit framed);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        s_tuser  <= {seq, first};
        do @(posedge clk); while (!s_tready);
        framed = sb.note_payload(data, first, last, seq);
    endtask

    task automatic send(input logic [DATA_W-1:0] data, input logic first,
                        input logic last, input logic seq);
        bit framed;
        send_payload(data, first, last, seq, framed);
    endtask

    task automatic apb_write(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic apb_check(input int idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'(idx * 4);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== sb.reg_value(idx))
            sb.report($sformatf("register %0d read", idx), prdata, sb.reg_value(idx));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Waits until every predicted byte has left the block, plus a margin for
    // transactions that yield nothing.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic check_registers();
        for (int i = 0; i < REG_COUNT; i++)
            apb_check(i);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2, 3:    return 8'h7E;
            4:       return 8'h7D;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 7))
            0, 1:    return sb.flag_byte;
            2:       return sb.escape_byte;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_settings();
        logic [7:0]  flag;
        logic [31:0] corrupt;
        flag = pick_byte();
        apb_write(REG_FLAG, {8'($urandom_range(0, 255)), 24'h0} | 32'(flag));
        // Now and then the escape value equals the flag.
        apb_write(REG_ESCAPE, ($urandom_range(0, 5) == 0) ? 32'(flag) : 32'(pick_byte()));
        apb_write(REG_MASK, 32'(pick_byte()));
        apb_write(REG_ADDRESS, ($urandom_range(0, 5) == 0) ? 32'(flag) : 32'(pick_byte()));
        case ($urandom_range(0, 5))
            0:       corrupt = 32'h0000_FFFF;
            1, 2:    corrupt = 32'(16'($urandom_range(1, 3)));
            default: corrupt = 32'h0;
        endcase
        apb_write(REG_CORRUPT, corrupt | {16'($urandom_range(0, 65535)), 16'h0});
        check_registers();
    endtask

    // Mostly well-formed packets with random content; about one step in ten sends
    // a single transaction with random marks instead.
    task automatic random_traffic(input int goal);
        int count;
        int len;
        bit framed;
        logic seq;
        count = 0;
        while (count < goal)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_payload(pick_payload(), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), framed);
                count += framed;
            end
            else
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12)
                                                  : $urandom_range(1, 5);
                seq = 1'($urandom_range(0, 1));
                for (int i = 0; i < len; i++)
                begin
                    // The sequence bit only matters on the first byte.
                    send_payload(pick_payload(), i == 0, i == len - 1,
                                 (i == 0) ? seq : 1'($urandom_range(0, 1)), framed);
                    count += framed;
                end
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_registers();
        // One-byte frame, then a frame whose payload holds flag and escape values.
        send(8'h00, 1'b1, 1'b1, 1'b0);
        send(8'h7E, 1'b1, 1'b0, 1'b1);
        send(8'h7D, 1'b0, 1'b0, 1'b0);
        send(8'hFF, 1'b0, 1'b0, 1'b1);
        send(8'h55, 1'b0, 1'b1, 1'b0);
        // Dropped: no frame is open.
        send(8'hAA, 1'b0, 1'b0, 1'b1);
        send(8'hAA, 1'b0, 1'b1, 1'b0);
        // A new first byte abandons the open frame.
        send(8'h11, 1'b1, 1'b0, 1'b0);
        send(8'h22, 1'b1, 1'b0, 1'b1);
        send(8'h5C, 1'b0, 1'b1, 1'b0);
        // The payload check itself equals the flag.
        send(8'h7E, 1'b1, 1'b1, 1'b1);
        settle();

        // Header equal to the flag, two corrupted frames, and a write that hits no register.
        apb_write(REG_ADDRESS, 32'h7E);
        apb_write(REG_CORRUPT, 32'h2);
        apb_write(REG_COUNT, 32'hA5);
        check_registers();
        send(8'h3C, 1'b1, 1'b1, 1'b1);
        send(8'h81, 1'b1, 1'b0, 1'b0);
        send(8'h7E, 1'b0, 1'b1, 1'b0);
        send(8'h7E, 1'b1, 1'b1, 1'b0);
        settle();

        // Flag equal to escape at the low extreme, mask and address at the high one.
        apb_write(REG_FLAG, 32'h00);
        apb_write(REG_ESCAPE, 32'h00);
        apb_write(REG_MASK, 32'hFF);
        apb_write(REG_ADDRESS, 32'hFF);
        apb_write(REG_CORRUPT, 32'hFFFF);
        check_registers();
        send(8'h00, 1'b1, 1'b0, 1'b1);
        send(8'h00, 1'b0, 1'b1, 1'b1);
        send(8'hFF, 1'b1, 1'b1, 1'b0);
        settle();

        for (int phase = 0; phase < 8; phase++)
        begin
            idle_on = (phase < 7);
            random_settings();
            random_traffic(40);
            settle();
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
